>>> hw/rtl/mcnts_pkg.sv
// Package for the mean color nearest tile selector.
// Holds the word types, register indexes and constants shared by the RTL,
// the mean divider and the checker. No dependencies.
package mcnts_pkg;

	localparam int MAX_PIXELS = 65536;
	localparam int MAX_IMAGES = 1024;
	localparam int CNT_W      = $clog2(MAX_PIXELS + 2);
	localparam int SUM_W      = 8 + $clog2(MAX_PIXELS + 1);
	localparam int POS_W      = $clog2(MAX_IMAGES + 1);
	localparam int IDX_W      = 10;
	localparam int DIST_W     = 10;
	localparam int MEAN_W     = 8;
	localparam int BIT_W      = $clog2(MEAN_W);
	localparam int CFG_IDX_W  = 8;
	localparam int NUM_CHAN   = 4;
	localparam int CHAN_W     = 2;

	localparam logic [DIST_W-1:0] START_DISTANCE = DIST_W'(255 * 4);

	localparam logic [CFG_IDX_W-1:0] REG_TARGET_RED   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_GREEN = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_BLUE  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_ALPHA = CFG_IDX_W'(3);

	typedef struct packed {
		logic [7:0] pix_red;
		logic [7:0] pix_green;
		logic [7:0] pix_blue;
		logic [7:0] pix_alpha;
		logic       end_of_image;
		logic       end_of_list;
	} pix_t;

	typedef struct packed {
		logic [IDX_W-1:0]  best_index;
		logic [DIST_W-1:0] best_distance;
		logic              found;
		logic              any_overflow;
	} res_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [MEAN_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> hw/rtl/mean_color_nearest_tile_select_unit.sv
// Mean color nearest tile selector: sums RGBA per image, divides at each scored image
// end and keeps the closest image. Uses mcnts_pkg and mcnts_mean_div.
// Throughput: one pixel word per cycle in the accumulate state; a scored image end holds
// input off while four means are formed in turn on the shared divider and a finish step
// runs, an excluded last image during the finish step alone. The result word is loaded
// in the finish step once the output is free. Reset clears targets and search.
module mean_color_nearest_tile_select_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  mcnts_pkg::pix_t                   in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output mcnts_pkg::res_t                   out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mcnts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                        cfg_data
);

	typedef enum logic [3:0] {
		ST_ACC   = 4'b0001,
		ST_START = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t state_q;

	logic [mcnts_pkg::SUM_W-1:0]  sum_q [mcnts_pkg::NUM_CHAN];
	logic [7:0]                   tgt_q [mcnts_pkg::NUM_CHAN];
	logic [mcnts_pkg::CNT_W-1:0]  cnt_q;
	logic [mcnts_pkg::POS_W-1:0]  pos_q;
	logic [mcnts_pkg::IDX_W-1:0]  best_pos_q;
	logic [mcnts_pkg::DIST_W-1:0] best_q;
	logic [mcnts_pkg::DIST_W-1:0] dist_q;
	logic [mcnts_pkg::CHAN_W-1:0] chan_q;
	logic                         match_q;
	logic                         ovf_q;
	logic                         eol_q;
	logic                         out_valid_q;
	mcnts_pkg::res_t              out_data_q;

	mcnts_pkg::div_req_t div_req;
	mcnts_pkg::div_rsp_t div_rsp;

	logic [7:0]                   pix_ch [mcnts_pkg::NUM_CHAN];
	logic [mcnts_pkg::SUM_W-1:0]  sum_nx [mcnts_pkg::NUM_CHAN];
	logic [mcnts_pkg::CNT_W-1:0]  cnt_nx;
	logic                         cnt_room;
	logic                         ovf_img;
	logic                         pos_ok;
	logic [mcnts_pkg::POS_W-1:0]  pos_inc;
	logic                         out_free;
	logic                         res_load;
	logic                         accept;
	logic [7:0]                   tgt_sel;
	logic [7:0]                   absd;
	logic                         better;
	logic [mcnts_pkg::IDX_W-1:0]  fin_pos;
	logic [mcnts_pkg::DIST_W-1:0] fin_best;
	logic                         fin_match;

	assign out_free  = ~out_valid_q | out_ready;
	assign res_load  = (state_q == ST_FIN) & eol_q & out_free;
	assign in_ready  = (state_q == ST_ACC);
	assign accept    = in_valid & in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		pix_ch[0] = in_data.pix_red;
		pix_ch[1] = in_data.pix_green;
		pix_ch[2] = in_data.pix_blue;
		pix_ch[3] = in_data.pix_alpha;
		cnt_room  = cnt_q < mcnts_pkg::CNT_W'(mcnts_pkg::MAX_PIXELS);
		for (int i = 0; i < mcnts_pkg::NUM_CHAN; i++) begin
			sum_nx[i] = cnt_room ? sum_q[i] + mcnts_pkg::SUM_W'(pix_ch[i]) : sum_q[i];
		end
		// An oversized image pins its count one above the limit.
		cnt_nx  = cnt_room ? cnt_q + 1'b1 : mcnts_pkg::CNT_W'(mcnts_pkg::MAX_PIXELS + 1);
		ovf_img = cnt_nx > mcnts_pkg::CNT_W'(mcnts_pkg::MAX_PIXELS);
		pos_ok  = pos_q < mcnts_pkg::POS_W'(mcnts_pkg::MAX_IMAGES);
		pos_inc = pos_ok ? pos_q + 1'b1 : pos_q;

		tgt_sel = tgt_q[chan_q];
		absd    = (tgt_sel >= div_rsp.quotient) ? tgt_sel - div_rsp.quotient
		                                        : div_rsp.quotient - tgt_sel;

		// Strictly smaller only, so ties keep the earlier image.
		better    = dist_q < best_q;
		fin_pos   = better ? pos_q[mcnts_pkg::IDX_W-1:0] : best_pos_q;
		fin_best  = better ? dist_q : best_q;
		fin_match = better | match_q;

		div_req.start    = (state_q == ST_START);
		div_req.dividend = sum_q[chan_q];
		div_req.divisor  = cnt_q;
	end

	mcnts_mean_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mcnts_pkg::NUM_CHAN; i++) begin
				tgt_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mcnts_pkg::REG_TARGET_RED:   tgt_q[0] <= cfg_data;
				mcnts_pkg::REG_TARGET_GREEN: tgt_q[1] <= cfg_data;
				mcnts_pkg::REG_TARGET_BLUE:  tgt_q[2] <= cfg_data;
				mcnts_pkg::REG_TARGET_ALPHA: tgt_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			for (int i = 0; i < mcnts_pkg::NUM_CHAN; i++) begin
				sum_q[i] <= '0;
			end
			cnt_q       <= '0;
			pos_q       <= '0;
			best_pos_q  <= '0;
			best_q      <= mcnts_pkg::START_DISTANCE;
			match_q     <= 1'b0;
			ovf_q       <= 1'b0;
			eol_q       <= 1'b0;
			chan_q      <= '0;
			dist_q      <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_ACC: begin
					if (accept) begin
						if (!in_data.end_of_image) begin
							sum_q <= sum_nx;
							cnt_q <= cnt_nx;
						end else if (ovf_img || !pos_ok) begin
							for (int i = 0; i < mcnts_pkg::NUM_CHAN; i++) begin
								sum_q[i] <= '0;
							end
							cnt_q <= '0;
							ovf_q <= ovf_q | ovf_img;
							if (in_data.end_of_list) begin
								// The start distance never wins, so the finish step
								// only closes the list with the search as it stands.
								eol_q   <= 1'b1;
								dist_q  <= mcnts_pkg::START_DISTANCE;
								state_q <= ST_FIN;
							end else begin
								pos_q <= pos_inc;
							end
						end else begin
							sum_q   <= sum_nx;
							cnt_q   <= cnt_nx;
							eol_q   <= in_data.end_of_list;
							chan_q  <= '0;
							dist_q  <= '0;
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_rsp.done) begin
						dist_q <= dist_q + mcnts_pkg::DIST_W'(absd);
						if (chan_q == mcnts_pkg::CHAN_W'(mcnts_pkg::NUM_CHAN - 1)) begin
							state_q <= ST_FIN;
						end else begin
							chan_q  <= chan_q + 1'b1;
							state_q <= ST_START;
						end
					end
				end
				ST_FIN: begin
					if (!eol_q || out_free) begin
						for (int i = 0; i < mcnts_pkg::NUM_CHAN; i++) begin
							sum_q[i] <= '0;
						end
						cnt_q   <= '0;
						state_q <= ST_ACC;
						if (eol_q) begin
							out_data_q.best_index    <= fin_pos;
							out_data_q.best_distance <= fin_best;
							out_data_q.found         <= fin_match;
							out_data_q.any_overflow  <= ovf_q;
							pos_q      <= '0;
							best_pos_q <= '0;
							best_q     <= mcnts_pkg::START_DISTANCE;
							match_q    <= 1'b0;
							ovf_q      <= 1'b0;
						end else begin
							best_pos_q <= fin_pos;
							best_q     <= fin_best;
							match_q    <= fin_match;
							pos_q      <= pos_inc;
						end
					end
				end
				default: begin
					state_q <= ST_ACC;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/mcnts_mean_div.sv
// Restoring divider that forms one truncated channel mean, one quotient bit
// per cycle. Depends on mcnts_pkg for widths and the request/response types.
module mcnts_mean_div (
	input  logic                clk,
	input  logic                arst_n,
	input  mcnts_pkg::div_req_t req,
	output mcnts_pkg::div_rsp_t rsp
);

	logic                         busy_q;
	logic                         done_q;
	logic [mcnts_pkg::BIT_W-1:0]  bit_q;
	logic [mcnts_pkg::SUM_W-1:0]  rem_q;
	logic [mcnts_pkg::CNT_W-1:0]  dvs_q;
	logic [mcnts_pkg::MEAN_W-1:0] quo_q;

	logic [mcnts_pkg::SUM_W-1:0] shifted;
	logic [mcnts_pkg::SUM_W:0]   diff;
	logic                        ge;

	// The mean never exceeds 255, so eight quotient bits cover every sum.
	always_comb begin
		shifted = mcnts_pkg::SUM_W'(dvs_q) << bit_q;
		diff    = {1'b0, rem_q} - {1'b0, shifted};
		ge      = ~diff[mcnts_pkg::SUM_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				bit_q  <= mcnts_pkg::BIT_W'(mcnts_pkg::MEAN_W - 1);
			end else if (busy_q) begin
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					bit_q <= bit_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			dvs_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff[mcnts_pkg::SUM_W-1:0];
			end
			quo_q <= {quo_q[mcnts_pkg::MEAN_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> hw/rtl/mcnts_checker.sv
// Port-level checker for the mean color nearest tile selector, bound to the
// top level. Depends on mcnts_pkg for the word types and the start distance.
module mcnts_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input mcnts_pkg::pix_t                 in_data,
	input logic                            out_valid,
	input logic                            out_ready,
	input mcnts_pkg::res_t                 out_data
);

	// A stalled result word must hold.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// With no match the search values stay at their start.
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |->
		out_data.best_distance == mcnts_pkg::START_DISTANCE && out_data.best_index == '0)
		else $error("empty search reported a position or distance");

	// A match is strictly below the start distance.
	a_found_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.found |-> out_data.best_distance < mcnts_pkg::START_DISTANCE)
		else $error("match reported at the start distance");

	// Only the last pixel of an image can produce a result word.
	a_no_mid_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_data.end_of_image |=> !$rose(out_valid))
		else $error("result word raised by a pixel inside an image");

endmodule

bind mean_color_nearest_tile_select_unit mcnts_checker u_mcnts_checker (.*);

>>> test/tb.sv
// Self-checking bench for mean_color_nearest_tile_select_unit.
// It scores every pixel word with its own model of the search and checks each result word.
// Depends on mcnts_pkg and the RTL of the unit only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mcnts_pkg::*;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int SETTLE       = 64;
	localparam int HOLD_CYCLES  = 600;
	localparam int PHASE_ITEMS  = 140;
	localparam int PRESS_ITEMS  = 48;
	localparam int LONG_LIST    = MAX_IMAGES + 6;

	typedef enum logic {ROW_PIXEL, ROW_TARGET} row_kind_e;
	typedef enum int {STYLE_RANDOM, STYLE_PALETTE, STYLE_NEAR, STYLE_EXTREME} color_style_e;
	typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_MOSTLY, RDY_RARE} ready_mode_e;

	typedef struct {
		row_kind_e kind;
		pix_t      px;
		bit        typed;
		res_t      want;
	} step_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	pix_t                 in_data;
	logic                 out_valid;
	logic                 out_ready;
	res_t                 out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	// Model of the search state and of the target color.
	logic [7:0]  target_color [NUM_CHAN];
	int unsigned chan_sum [NUM_CHAN];
	int unsigned pix_count;
	int unsigned img_pos;
	int unsigned best_pos;
	int unsigned best_dist;
	bit          match_flag;
	bit          ovf_flag;

	res_t        result_q [$];
	step_row_t   steps [$];
	int          errors;
	int          pixels_sent;
	int          burst_left;
	int          hold_asks;
	int          hold_taken;
	int unsigned cycle_count;

	mean_color_nearest_tile_select_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(string msg);
		$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	function automatic void clear_image();
		for (int c = 0; c < NUM_CHAN; c++)
			chan_sum[c] = 0;
		pix_count = 0;
	endfunction

	function automatic void clear_search();
		clear_image();
		img_pos = 0;
		best_pos = 0;
		best_dist = START_DISTANCE;
		match_flag = 1'b0;
		ovf_flag = 1'b0;
	endfunction

	// Advances the model by one pixel word; returns 1 when it closes the list.
	function automatic bit score_pixel(input pix_t px, output res_t r);
		int unsigned val [NUM_CHAN];
		int unsigned mean_v;
		int unsigned dist_sum;
		val[0] = px.pix_red;
		val[1] = px.pix_green;
		val[2] = px.pix_blue;
		val[3] = px.pix_alpha;
		r = '0;
		if (pix_count < MAX_PIXELS) begin
			for (int c = 0; c < NUM_CHAN; c++)
				chan_sum[c] += val[c];
			pix_count++;
		end else begin
			pix_count = MAX_PIXELS + 1;
		end
		if (!px.end_of_image)
			return 1'b0;
		if (pix_count > MAX_PIXELS) begin
			ovf_flag = 1'b1;
		end else if (img_pos < MAX_IMAGES) begin
			dist_sum = 0;
			for (int c = 0; c < NUM_CHAN; c++) begin
				mean_v = chan_sum[c] / pix_count;
				dist_sum += (target_color[c] >= mean_v) ? target_color[c] - mean_v
					: mean_v - target_color[c];
			end
			// A tie keeps the earlier image.
			if (dist_sum < best_dist) begin
				best_dist = dist_sum;
				best_pos = img_pos;
				match_flag = 1'b1;
			end
		end
		if (img_pos < MAX_IMAGES)
			img_pos++;
		clear_image();
		if (!px.end_of_list)
			return 1'b0;
		r.best_index = IDX_W'(best_pos);
		r.best_distance = DIST_W'(best_dist);
		r.found = match_flag;
		r.any_overflow = ovf_flag;
		clear_search();
		return 1'b1;
	endfunction

	// The sender runs in bursts; between bursts valid drops for a random gap.
	task automatic pace();
		int gap;
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(100, 400)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Called at a falling edge; returns at a falling edge once the word is taken and any gap between bursts has passed.
	task automatic send_pixel(input pix_t px, input bit typed, input res_t want);
		res_t r;
		in_valid <= 1'b1;
		in_data <= px;
		forever begin
			@(posedge clk);
			if (in_ready)
				break;
		end
		if (score_pixel(px, r))
			result_q.push_back(typed ? want : r);
		pixels_sent++;
		@(negedge clk);
		pace();
	endtask

	// Lets every expected word drain and any image scoring finish.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (result_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic cfg_word(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		case (idx)
			REG_TARGET_RED:   target_color[0] = val;
			REG_TARGET_GREEN: target_color[1] = val;
			REG_TARGET_BLUE:  target_color[2] = val;
			REG_TARGET_ALPHA: target_color[3] = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Writes the four targets, then one word to an unused index that must be ignored.
	task automatic write_targets(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] a);
		cfg_word(REG_TARGET_RED, r);
		cfg_word(REG_TARGET_GREEN, g);
		cfg_word(REG_TARGET_BLUE, b);
		cfg_word(REG_TARGET_ALPHA, a);
		cfg_word(CFG_IDX_W'($urandom_range(NUM_CHAN, 255)), 8'($urandom_range(0, 255)));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] rand_chan(color_style_e s, logic [7:0] t);
		int v;
		case (s)
			STYLE_NEAR: begin
				v = int'(t) + int'($urandom_range(0, 6)) - 3;
				if (v < 0)
					v = 0;
				if (v > 255)
					v = 255;
			end
			STYLE_EXTREME: v = $urandom_range(0, 1) ? 255 : 0;
			default: v = $urandom_range(0, 255);
		endcase
		return 8'(v);
	endfunction

	function automatic pix_t rand_color(color_style_e s);
		pix_t px;
		px = '0;
		px.pix_red = rand_chan(s, target_color[0]);
		px.pix_green = rand_chan(s, target_color[1]);
		px.pix_blue = rand_chan(s, target_color[2]);
		px.pix_alpha = rand_chan(s, target_color[3]);
		return px;
	endfunction

	// One well-formed candidate list with random content.
	task automatic send_list();
		int n_img;
		int len;
		int pick;
		color_style_e style;
		pix_t pal [3];
		pix_t px;
		n_img = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
		style = color_style_e'($urandom_range(0, 3));
		for (int k = 0; k < 3; k++)
			pal[k] = rand_color(STYLE_RANDOM);
		for (int i = 0; i < n_img; i++) begin
			pick = $urandom_range(0, 19);
			if (pick < 14)
				len = $urandom_range(1, 3);
			else if (pick < 19)
				len = $urandom_range(4, 12);
			else
				len = $urandom_range(13, 40);
			for (int j = 0; j < len; j++) begin
				px = (style == STYLE_PALETTE) ? pal[$urandom_range(0, 2)] : rand_color(style);
				px.end_of_image = (j == len - 1);
				// A list mark away from an image end must be ignored.
				px.end_of_list = px.end_of_image ? (i == n_img - 1) : ($urandom_range(0, 19) == 0);
				send_pixel(px, 1'b0, '0);
			end
		end
	endtask

	function automatic step_row_t make_row(row_kind_e kind, int r, int g, int b, int a,
			bit eoi, bit eol, bit typed, int idx, int dist_v, bit fnd, bit ovf);
		step_row_t s;
		s.kind = kind;
		s.px.pix_red = 8'(r);
		s.px.pix_green = 8'(g);
		s.px.pix_blue = 8'(b);
		s.px.pix_alpha = 8'(a);
		s.px.end_of_image = eoi;
		s.px.end_of_list = eol;
		s.typed = typed;
		s.want.best_index = IDX_W'(idx);
		s.want.best_distance = DIST_W'(dist_v);
		s.want.found = fnd;
		s.want.any_overflow = ovf;
		return s;
	endfunction

	// Receiver: ready follows random patterns, with a long hold-off on request.
	initial begin : receiver
		ready_mode_e mode;
		int seg_left;
		int hold_left;
		out_ready <= 1'b0;
		mode = RDY_ALWAYS;
		seg_left = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_asks != hold_taken) begin
				hold_taken = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode = ready_mode_e'($urandom_range(0, 3));
					seg_left = $urandom_range(4, 60);
				end
				seg_left--;
				case (mode)
					RDY_ALWAYS: out_ready <= 1'b1;
					RDY_HALF:   out_ready <= 1'($urandom_range(0, 1));
					RDY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
					default:    out_ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (result_q.size() == 0) begin
				report($sformatf("result word %h with nothing expected", out_data));
			end else begin
				want = result_q.pop_front();
				if (out_data.best_index !== want.best_index)
					report($sformatf("best_index %0d, expected %0d",
						out_data.best_index, want.best_index));
				if (out_data.best_distance !== want.best_distance)
					report($sformatf("best_distance %0d, expected %0d",
						out_data.best_distance, want.best_distance));
				if (out_data.found !== want.found)
					report($sformatf("found %b, expected %b", out_data.found, want.found));
				if (out_data.any_overflow !== want.any_overflow)
					report($sformatf("any_overflow %b, expected %b",
						out_data.any_overflow, want.any_overflow));
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		pix_t px;
		int start;
		bit paused;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		errors = 0;
		pixels_sent = 0;
		burst_left = 0;
		hold_asks = 0;
		hold_taken = 0;
		paused = 1'b0;
		for (int c = 0; c < NUM_CHAN; c++)
			target_color[c] = '0;
		clear_search();

		// Targets start at zero: a white image ties the start distance and finds nothing.
		steps.push_back(make_row(ROW_PIXEL, 255, 255, 255, 255, 1, 1, 1, 0, 1020, 0, 0));
		steps.push_back(make_row(ROW_PIXEL, 0, 0, 0, 0, 1, 1, 1, 0, 0, 1, 0));
		steps.push_back(make_row(ROW_PIXEL, 255, 0, 255, 0, 0, 1, 0, 0, 0, 0, 0));
		steps.push_back(make_row(ROW_PIXEL, 1, 2, 3, 4, 1, 0, 0, 0, 0, 0, 0));
		steps.push_back(make_row(ROW_PIXEL, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
		steps.push_back(make_row(ROW_PIXEL, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0));
		steps.push_back(make_row(ROW_PIXEL, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		steps.push_back(make_row(ROW_PIXEL, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		steps.push_back(make_row(ROW_PIXEL, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0));
		steps.push_back(make_row(ROW_TARGET, 255, 255, 255, 255, 0, 0, 0, 0, 0, 0, 0));
		steps.push_back(make_row(ROW_PIXEL, 0, 0, 0, 0, 1, 1, 1, 0, 1020, 0, 0));
		steps.push_back(make_row(ROW_PIXEL, 255, 255, 255, 255, 1, 1, 1, 0, 0, 1, 0));
		steps.push_back(make_row(ROW_TARGET, 0, 255, 0, 255, 0, 0, 0, 0, 0, 0, 0));
		steps.push_back(make_row(ROW_PIXEL, 0, 255, 0, 255, 1, 1, 1, 0, 0, 1, 0));
		steps.push_back(make_row(ROW_PIXEL, 255, 0, 255, 0, 1, 1, 1, 0, 1020, 0, 0));
		steps.push_back(make_row(ROW_TARGET, 200, 100, 50, 25, 0, 0, 0, 0, 0, 0, 0));
		steps.push_back(make_row(ROW_PIXEL, 201, 99, 52, 20, 0, 0, 0, 0, 0, 0, 0));
		steps.push_back(make_row(ROW_PIXEL, 199, 101, 48, 30, 1, 0, 0, 0, 0, 0, 0));
		steps.push_back(make_row(ROW_PIXEL, 10, 10, 10, 10, 1, 0, 0, 0, 0, 0, 0));
		steps.push_back(make_row(ROW_PIXEL, 200, 100, 50, 25, 1, 1, 0, 0, 0, 0, 0));
		steps.push_back(make_row(ROW_PIXEL, 128, 128, 128, 128, 0, 0, 0, 0, 0, 0, 0));
		steps.push_back(make_row(ROW_PIXEL, 127, 127, 127, 127, 1, 1, 0, 0, 0, 0, 0));

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		foreach (steps[i]) begin
			if (steps[i].kind == ROW_TARGET) begin
				wait_idle();
				write_targets(steps[i].px.pix_red, steps[i].px.pix_green,
					steps[i].px.pix_blue, steps[i].px.pix_alpha);
			end else begin
				send_pixel(steps[i].px, steps[i].typed, steps[i].want);
			end
		end

		// More images than positions: the closest ones sit past the last position.
		wait_idle();
		write_targets(0, 0, 0, 0);
		for (int p = 0; p < LONG_LIST; p++) begin
			if (p < MAX_IMAGES - 1) begin
				px.pix_red = 8'($urandom_range(8, 255));
				px.pix_green = 8'($urandom_range(8, 255));
				px.pix_blue = 8'($urandom_range(8, 255));
				px.pix_alpha = 8'($urandom_range(8, 255));
			end else if (p == MAX_IMAGES - 1) begin
				px = make_row(ROW_PIXEL, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0).px;
			end else begin
				px = '0;
			end
			px.end_of_image = 1'b1;
			px.end_of_list = (p == LONG_LIST - 1);
			send_pixel(px, 1'b0, '0);
		end

		for (int ph = 0; ph < 4; ph++) begin
			wait_idle();
			if (ph == 1)
				write_targets($urandom_range(0, 1) ? 255 : 0, $urandom_range(0, 1) ? 255 : 0,
					$urandom_range(0, 1) ? 255 : 0, $urandom_range(0, 1) ? 255 : 0);
			else
				write_targets($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255));
			start = pixels_sent;
			if (ph == 1) begin
				// Single-pixel lists while the receiver holds off fill the unit up.
				hold_asks++;
				repeat (PRESS_ITEMS) begin
					px = rand_color(STYLE_RANDOM);
					px.end_of_image = 1'b1;
					px.end_of_list = 1'b1;
					send_pixel(px, 1'b0, '0);
				end
			end
			while (pixels_sent - start < PHASE_ITEMS) begin
				if (ph == 2 && !paused && pixels_sent - start > PHASE_ITEMS / 2) begin
					wait_idle();
					paused = 1'b1;
				end
				if ($urandom_range(0, 99) < 85) begin
					send_list();
				end else begin
					px = rand_color(STYLE_RANDOM);
					px.end_of_image = 1'($urandom_range(0, 1));
					px.end_of_list = 1'($urandom_range(0, 1));
					send_pixel(px, 1'b0, '0);
				end
			end
		end

		wait_idle();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/mcnts_pkg.sv
hw/rtl/mcnts_mean_div.sv
hw/rtl/mean_color_nearest_tile_select_unit.sv
hw/rtl/mcnts_checker.sv
test/tb.sv
